@@ hdl/mfce_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constant tables of the motion and feeder command engine.
// No dependencies.
package mfce_pkg;

    localparam int AXIS_SLOTS_DEF   = 3;
    localparam int FEEDER_COUNT_DEF = 20;
    localparam int SLOT_MAX_W       = 3;
    localparam int CFG_SLOTS        = 3;
    localparam int QUEUE_DEPTH      = 4;

    localparam int CURVE_POINTS = 9;
    localparam int SEG_W        = $clog2(CURVE_POINTS);
    localparam int SPAN_W       = 7;

    localparam logic [15:0] CURVE_RPM [CURVE_POINTS] =
        '{16'd0, 16'd50, 16'd100, 16'd200, 16'd300, 16'd400, 16'd500, 16'd600, 16'd700};
    localparam logic [7:0] CURVE_PWM [CURVE_POINTS] =
        '{8'd0, 8'd20, 8'd40, 8'd80, 8'd120, 8'd160, 8'd200, 8'd230, 8'd255};
    // rise / span of each segment as a 0.16 fraction, rounded up
    localparam logic [15:0] CURVE_MUL [CURVE_POINTS] =
        '{16'd0, 16'd26215, 16'd26215, 16'd26215, 16'd26215, 16'd26215, 16'd19661,
          16'd16384, 16'd0};

    localparam logic [7:0]  ID_RESET  [CFG_SLOTS] = '{8'd2, 8'd3, 8'd4};
    localparam logic [15:0] SPM_RESET [CFG_SLOTS] = '{16'd800, 16'd500, 16'd500};
    localparam logic [7:0]  ID_RESET_EXTRA  = 8'd255;
    localparam logic [15:0] SPM_RESET_EXTRA = 16'd500;

    typedef enum logic [2:0] {
        CMD_MOVE  = 3'd0,
        CMD_HOME  = 3'd1,
        CMD_START = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_SPEED = 3'd4,
        CMD_DIR   = 3'd5,
        CMD_HALT  = 3'd6,
        CMD_ECHO  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ID0  = 3'd0,
        REG_ID1  = 3'd1,
        REG_ID2  = 3'd2,
        REG_SPM0 = 3'd3,
        REG_SPM1 = 3'd4,
        REG_SPM2 = 3'd5
    } t_reg;

    typedef struct packed {
        logic                    ack;
        t_cmd                    code;
        logic [7:0]              arg_one;
        logic [7:0]              arg_two;
        logic                    drive;
        logic [4:0]              feeder;
        logic [7:0]              pwm;
        logic                    stop;
        logic                    is_move;
        logic                    is_home;
        logic [SLOT_MAX_W-1:0]   slot;
        logic signed [31:0]      target;
    } t_item;

    typedef struct packed {
        logic               ack_valid;
        logic [2:0]         ack_code;
        logic [7:0]         ack_arg_one;
        logic [7:0]         ack_arg_two;
        logic               drive_valid;
        logic [4:0]         drive_feeder;
        logic [7:0]         drive_pwm;
        logic               all_stop;
        logic               step_valid;
        logic [1:0]         step_slot;
        logic signed [31:0] step_count;
    } t_result;

endpackage

@@ hdl/mfce_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command words, matches axis slots, checks feeder range, maps rpm to duty.
// Depends on mfce_pkg.
module mfce_front #(
    parameter int AXIS_SLOTS   = mfce_pkg::AXIS_SLOTS_DEF,
    parameter int FEEDER_COUNT = mfce_pkg::FEEDER_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_axis_id [AXIS_SLOTS],
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_req_type,
    input  logic [7:0]          i_channel,
    input  logic [15:0]         i_speed_rpm,
    input  logic [7:0]          i_direction_code,
    input  logic signed [31:0]  i_target_pos,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output mfce_pkg::t_item     o_push_item
);
    import mfce_pkg::*;

    localparam logic [8:0] FEED_LIMIT = 9'(FEEDER_COUNT);

    logic                  r_valid;
    t_item                 r_item;
    t_item                 n_item;
    logic                  hit;
    logic [SLOT_MAX_W-1:0] hit_slot;
    logic                  feeder_ok;
    logic [SEG_W-1:0]      seg;
    logic [15:0]           seg_off;
    logic [SPAN_W-1:0]     span_off;
    logic [22:0]           frac_prod;
    logic [7:0]            seg_pwm;
    logic [7:0]            duty;
    logic                  accept;

    assign o_ready      = !r_valid || i_push_ready;
    assign accept       = i_valid && o_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int s = AXIS_SLOTS - 1; s >= 0; s--) begin
            if (i_axis_id[s] == i_channel) begin
                hit      = 1'b1;
                hit_slot = SLOT_MAX_W'(s);
            end
        end
    end

    assign feeder_ok = {1'b0, i_channel} < FEED_LIMIT;

    always_comb begin
        seg = '0;
        for (int k = CURVE_POINTS - 2; k >= 1; k--) begin
            if (i_speed_rpm <= CURVE_RPM[k + 1]) begin
                seg = SEG_W'(k);
            end
        end
        seg_off   = i_speed_rpm - CURVE_RPM[seg];
        span_off  = seg_off[SPAN_W-1:0];
        frac_prod = 23'(span_off) * 23'(CURVE_MUL[seg]);
        seg_pwm   = CURVE_PWM[seg] + 8'(frac_prod[22:16]);
        priority if (i_speed_rpm == '0) begin
            duty = '0;
        end else if (i_speed_rpm <= CURVE_RPM[1]) begin
            duty = CURVE_PWM[1];
        end else if (i_speed_rpm >= CURVE_RPM[CURVE_POINTS - 1]) begin
            duty = CURVE_PWM[CURVE_POINTS - 1];
        end else begin
            duty = seg_pwm;
        end
    end

    always_comb begin
        n_item = '0;
        if (!i_req_type[3]) begin
            unique case (t_cmd'(i_req_type[2:0]))
                CMD_MOVE, CMD_HOME: begin
                    if (hit) begin
                        n_item.ack     = 1'b1;
                        n_item.code    = t_cmd'(i_req_type[2:0]);
                        n_item.arg_one = i_channel;
                        n_item.slot    = hit_slot;
                        n_item.target  = i_target_pos;
                        n_item.is_move = (i_req_type[2:0] == CMD_MOVE);
                        n_item.is_home = (i_req_type[2:0] == CMD_HOME);
                    end
                end
                CMD_START, CMD_SPEED: begin
                    if (feeder_ok) begin
                        n_item.ack     = 1'b1;
                        n_item.code    = t_cmd'(i_req_type[2:0]);
                        n_item.arg_one = i_channel;
                        n_item.arg_two = duty;
                        n_item.drive   = 1'b1;
                        n_item.feeder  = i_channel[4:0];
                        n_item.pwm     = duty;
                    end
                end
                CMD_STOP: begin
                    if (feeder_ok) begin
                        n_item.ack     = 1'b1;
                        n_item.code    = CMD_STOP;
                        n_item.arg_one = i_channel;
                        n_item.drive   = 1'b1;
                        n_item.feeder  = i_channel[4:0];
                    end
                end
                CMD_DIR: begin
                    if (feeder_ok) begin
                        n_item.ack     = 1'b1;
                        n_item.code    = CMD_DIR;
                        n_item.arg_one = i_channel;
                        n_item.arg_two = i_direction_code;
                    end
                end
                CMD_HALT: begin
                    n_item.stop = 1'b1;
                end
                CMD_ECHO: begin
                    n_item.ack  = 1'b1;
                    n_item.code = CMD_ECHO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hdl/mfce_queue.sv @@
`timescale 1ns / 1ps
// Short word queue between the front end and the execution back end.
// Depends on mfce_pkg.
module mfce_queue #(
    parameter int DEPTH = mfce_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  mfce_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output mfce_pkg::t_item o_pop_item
);
    import mfce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ hdl/mfce_back.sv @@
`timescale 1ns / 1ps
// Back end: axis position store, step count multiply, saturation and the result register.
// Depends on mfce_pkg.
module mfce_back #(
    parameter int AXIS_SLOTS = mfce_pkg::AXIS_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_axis_spm [AXIS_SLOTS],
    input  logic              i_head_valid,
    output logic              o_head_ready,
    input  mfce_pkg::t_item   i_head,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output mfce_pkg::t_result o_res
);
    import mfce_pkg::*;

    localparam int SLOT_W = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;

    logic signed [31:0] r_pos [AXIS_SLOTS];
    logic               r_s1_valid;
    t_item              r_s1;
    logic               r_s1_neg;
    logic [31:0]        r_s1_q;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;

    logic               s_adv;
    logic               pop;
    logic [SLOT_W-1:0]  slot_idx;
    logic [32:0]        delta;
    logic [32:0]        mag;
    logic [47:0]        prod;
    logic [31:0]        q;
    logic [31:0]        q_sat;

    assign s_adv        = !r_out_valid || i_res_ready;
    assign o_head_ready = !r_s1_valid || s_adv;
    assign pop          = i_head_valid && o_head_ready;
    assign slot_idx     = i_head.slot[SLOT_W-1:0];

    always_comb begin
        delta = {i_head.target[31], i_head.target} - {r_pos[slot_idx][31], r_pos[slot_idx]};
        mag   = delta[32] ? (~delta + 33'd1) : delta;
        prod  = 48'(mag[31:0]) * 48'(i_axis_spm[slot_idx]);
        q     = prod[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < AXIS_SLOTS; s++) begin
                r_pos[s] <= '0;
            end
        end else if (pop && i_head.is_move && (q != '0)) begin
            r_pos[slot_idx] <= i_head.target;
        end else if (pop && i_head.is_home) begin
            r_pos[slot_idx] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_head_ready) begin
            r_s1_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1     <= i_head;
            r_s1_neg <= delta[32];
            r_s1_q   <= q;
        end
    end

    always_comb begin
        if (r_s1_neg) begin
            q_sat = (r_s1_q > 32'h8000_0000) ? 32'h8000_0000 : r_s1_q;
        end else begin
            q_sat = (r_s1_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_s1_q;
        end
        n_out              = '0;
        n_out.ack_valid    = r_s1.ack;
        n_out.ack_code     = r_s1.code;
        n_out.ack_arg_one  = r_s1.arg_one;
        n_out.ack_arg_two  = r_s1.arg_two;
        n_out.drive_valid  = r_s1.drive;
        n_out.drive_feeder = r_s1.feeder;
        n_out.drive_pwm    = r_s1.pwm;
        n_out.all_stop     = r_s1.stop;
        if (r_s1.is_move) begin
            n_out.step_valid = 1'b1;
            n_out.step_slot  = 2'(r_s1.slot);
            n_out.step_count = r_s1_neg ? -q_sat : q_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s_adv |=> r_out_valid)
        else $error("stage word lost on advance");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out.step_valid, r_out.drive_valid, r_out.all_stop}))
        else $error("result carries more than one action");

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.all_stop |-> !r_out.ack_valid)
        else $error("estop result acknowledged");

    a_step_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.step_valid |-> r_out.ack_valid && (r_out.ack_code == CMD_MOVE))
        else $error("step count without move acknowledgement");

    a_home_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_head.is_home |=> r_pos[$past(slot_idx)] == '0)
        else $error("home did not clear position");

endmodule

@@ hdl/motion_feeder_command_engine.sv @@
`timescale 1ns / 1ps
// Top level of the motion and feeder command engine: configuration registers and the
// front end, queue and back end. Depends on mfce_pkg, mfce_front, mfce_queue, mfce_back.
//
//  channel   handshake                  payload
//  cfg       i_cfg_we                   i_cfg_idx, i_cfg_wdata
//  command   i_cmd_valid / o_cmd_ready  i_req_type .. i_target_pos
//  result    o_res_valid / i_res_ready  o_ack_valid .. o_step_count
//
//  One command word per cycle sustained while results are taken; each accepted command's
//  result word passes the input register, then queue, multiply stage, result register.
//  The step multiply and the position update share one cycle, so moves to the same
//  axis follow back to back. Reset is synchronous, clears positions, restores config.
//  The queue absorbs result-side stalls; command ready drops only when the queue and
//  the input register are both full.
module motion_feeder_command_engine #(
    parameter int AXIS_SLOTS   = mfce_pkg::AXIS_SLOTS_DEF,
    parameter int FEEDER_COUNT = mfce_pkg::FEEDER_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  logic [3:0]         i_req_type,
    input  logic [7:0]         i_channel,
    input  logic [15:0]        i_speed_rpm,
    input  logic [7:0]         i_direction_code,
    input  logic signed [31:0] i_target_pos,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_ack_valid,
    output logic [2:0]         o_ack_code,
    output logic [7:0]         o_ack_arg_one,
    output logic [7:0]         o_ack_arg_two,
    output logic               o_drive_valid,
    output logic [4:0]         o_drive_feeder,
    output logic [7:0]         o_drive_pwm,
    output logic               o_all_stop,
    output logic               o_step_valid,
    output logic [1:0]         o_step_slot,
    output logic signed [31:0] o_step_count
);
    import mfce_pkg::*;

    logic [7:0]  axis_id  [AXIS_SLOTS];
    logic [15:0] axis_spm [AXIS_SLOTS];

    logic    push_valid;
    logic    push_ready;
    t_item   push_item;
    logic    head_valid;
    logic    head_ready;
    t_item   head_item;
    t_result res;

    for (genvar g = 0; g < AXIS_SLOTS; g++) begin : g_slot
        if (g < CFG_SLOTS) begin : g_cfg
            localparam logic [2:0] ID_IDX  = 3'(REG_ID0) + 3'(g);
            localparam logic [2:0] SPM_IDX = 3'(REG_SPM0) + 3'(g);
            logic [7:0]  r_id;
            logic [15:0] r_spm;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_id  <= ID_RESET[g];
                    r_spm <= SPM_RESET[g];
                end else if (i_cfg_we) begin
                    if (i_cfg_idx == ID_IDX) begin
                        r_id <= i_cfg_wdata[7:0];
                    end
                    if (i_cfg_idx == SPM_IDX) begin
                        r_spm <= i_cfg_wdata;
                    end
                end
            end
            assign axis_id[g]  = r_id;
            assign axis_spm[g] = r_spm;
        end else begin : g_fixed
            assign axis_id[g]  = ID_RESET_EXTRA;
            assign axis_spm[g] = SPM_RESET_EXTRA;
        end
    end

    mfce_front #(
        .AXIS_SLOTS   (AXIS_SLOTS),
        .FEEDER_COUNT (FEEDER_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_axis_id        (axis_id),
        .i_valid          (i_cmd_valid),
        .o_ready          (o_cmd_ready),
        .i_req_type       (i_req_type),
        .i_channel        (i_channel),
        .i_speed_rpm      (i_speed_rpm),
        .i_direction_code (i_direction_code),
        .i_target_pos     (i_target_pos),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_push_item      (push_item)
    );

    mfce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (head_valid),
        .i_pop_ready  (head_ready),
        .o_pop_item   (head_item)
    );

    mfce_back #(
        .AXIS_SLOTS (AXIS_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_axis_spm   (axis_spm),
        .i_head_valid (head_valid),
        .o_head_ready (head_ready),
        .i_head       (head_item),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (res)
    );

    assign o_ack_valid    = res.ack_valid;
    assign o_ack_code     = res.ack_code;
    assign o_ack_arg_one  = res.ack_arg_one;
    assign o_ack_arg_two  = res.ack_arg_two;
    assign o_drive_valid  = res.drive_valid;
    assign o_drive_feeder = res.drive_feeder;
    assign o_drive_pwm    = res.drive_pwm;
    assign o_all_stop     = res.all_stop;
    assign o_step_valid   = res.step_valid;
    assign o_step_slot    = res.step_slot;
    assign o_step_count   = res.step_count;

endmodule
